[sv/srct_pkg.sv]
// ============================================================================
// srct_pkg
// Shared types and constants for the subpixel ray cell traversal block.
// ============================================================================
package srct_pkg;

    localparam int COORD_W            = 15;
    localparam int CELL_W             = 5;
    localparam int GRID_CELLS_DEF     = 32;
    localparam int SUBPIXEL_SCALE_DEF = 1000;
    localparam int MAX_RESULTS        = 63;
    localparam int CNT_W              = 6;
    localparam int S_TDATA_W          = 64;
    localparam int M_TDATA_W          = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_MUL,
        ST_INIT,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic prep;
        logic mul;
        logic init;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic cell_last;
    } sts_t;

endpackage

[sv/srct_dp.sv]
// ============================================================================
// srct_dp
// Datapath: input clamp and ordering, cell index division, error term setup
// and the per-cell walk with its output payload register.
// ============================================================================
module srct_dp #(
    parameter int GRID_CELLS     = srct_pkg::GRID_CELLS_DEF,
    parameter int SUBPIXEL_SCALE = srct_pkg::SUBPIXEL_SCALE_DEF
) (
    input  logic                         aclk,
    input  srct_pkg::cmd_t               cmd,
    output srct_pkg::sts_t               sts,
    input  logic [srct_pkg::COORD_W-1:0] start_x,
    input  logic [srct_pkg::COORD_W-1:0] start_y,
    input  logic [srct_pkg::COORD_W-1:0] stop_x,
    input  logic [srct_pkg::COORD_W-1:0] stop_y,
    output logic [srct_pkg::CELL_W-1:0]  cell_x,
    output logic [srct_pkg::CELL_W-1:0]  cell_y,
    output logic                         last_cell
);

    localparam int CW    = srct_pkg::COORD_W;
    localparam int LW    = srct_pkg::CELL_W;
    localparam int QW    = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int SW    = $clog2(SUBPIXEL_SCALE + 1);
    localparam int RW    = SW + 1;
    localparam int ERR_W = SW + 20;
    localparam int MW    = CW + 2;
    localparam int PW    = CW + MW;
    localparam int DIV_K = CW + SW;
    localparam longint LIM = longint'(GRID_CELLS) * longint'(SUBPIXEL_SCALE) - 1;
    localparam logic [CW-1:0] LIM_C =
        (LIM >= ((longint'(1) << CW) - 1)) ? {CW{1'b1}} : CW'(LIM);
    localparam logic [RW-1:0] TWO_S      = RW'(2 * SUBPIXEL_SCALE);
    localparam logic [RW-1:0] TWO_S_M1   = RW'(2 * SUBPIXEL_SCALE - 1);
    // ceil(2^DIV_K / scale): exact quotient for every CW-bit coordinate
    localparam longint DIV_M = ((longint'(1) << DIV_K) + longint'(SUBPIXEL_SCALE) - 1)
                               / longint'(SUBPIXEL_SCALE);
    localparam logic [PW-1:0] RECIP_C  = PW'(DIV_M);
    localparam logic [CW-1:0] SCALE_CW = CW'(SUBPIXEL_SCALE);

    // lanes: 0 begin x, 1 begin y, 2 end x, 3 end y
    logic [CW-1:0]  coord_reg [4];
    logic [CW-1:0]  rem_reg   [4];
    logic [QW-1:0]  quot_reg  [4];
    logic           div_phase_reg;
    logic [PW-1:0]  recip_w   [4];

    logic [CW-1:0]          dx_reg;
    logic signed [CW:0]     dy_reg;
    logic                   vert_reg;
    logic                   rising_reg;
    logic [RW-1:0]          first_reg;
    logic [RW-1:0]          lastw_reg;
    logic [RW-1:0]          ey1_reg;

    logic signed [ERR_W-1:0] p1_reg, p2_reg, den_reg, step_reg, dyl_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [LW-1:0]           cx_reg, cy_reg, ymax_reg, ecx_reg;
    logic                    final_reg;
    logic [srct_pkg::CNT_W-1:0] cnt_reg;
    logic [LW-1:0]           cell_x_reg, cell_y_reg;
    logic                    last_cell_reg;

    logic [CW-1:0] sx, sy, tx, ty;
    logic          swap;

    logic [CW+RW-1:0]          p1_w;
    logic signed [CW+RW+1:0]   p2_w;
    logic [CW+RW-1:0]          den_w;
    logic signed [CW+RW+1:0]   step_w;
    logic signed [CW+RW+1:0]   dyl_w;

    logic                    adv_y, corner, fin_next, cell_last;
    logic signed [ERR_W-1:0] err_adj, err_col;
    logic [LW-1:0]           cy_step, cx_inc;

    always_comb begin
        sx   = (start_x > LIM_C) ? LIM_C : start_x;
        sy   = (start_y > LIM_C) ? LIM_C : start_y;
        tx   = (stop_x  > LIM_C) ? LIM_C : stop_x;
        ty   = (stop_y  > LIM_C) ? LIM_C : stop_y;
        swap = sx > tx;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            recip_w[i] = PW'(coord_reg[i]) * RECIP_C;
        end
    end

    assign p1_w   = ey1_reg * dx_reg;
    assign p2_w   = dy_reg * $signed({1'b0, first_reg});
    assign den_w  = dx_reg * TWO_S;
    assign step_w = dy_reg * $signed({1'b0, TWO_S});
    assign dyl_w  = dy_reg * $signed({1'b0, lastw_reg});

    always_comb begin
        if (vert_reg) begin
            adv_y = cy_reg != ymax_reg;
        end else if (rising_reg) begin
            adv_y = err_reg > den_reg;
        end else begin
            adv_y = err_reg < 0;
        end
        corner    = rising_reg ? (err_reg == den_reg) : (err_reg == '0);
        err_adj   = rising_reg ? (err_reg - den_reg) : (err_reg + den_reg);
        cy_step   = (rising_reg || vert_reg) ? (cy_reg + 1'b1) : (cy_reg - 1'b1);
        cx_inc    = cx_reg + 1'b1;
        fin_next  = cx_inc == ecx_reg;
        err_col   = (corner ? err_adj : err_reg) + (fin_next ? dyl_reg : step_reg);
        cell_last = (!adv_y && (vert_reg || final_reg))
                    || (cnt_reg == srct_pkg::CNT_W'(srct_pkg::MAX_RESULTS - 1));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            coord_reg[0]  <= swap ? tx : sx;
            coord_reg[1]  <= swap ? ty : sy;
            coord_reg[2]  <= swap ? sx : tx;
            coord_reg[3]  <= swap ? sy : ty;
            div_phase_reg <= 1'b1;
        end else if (cmd.div_step) begin
            if (div_phase_reg) begin
                for (int i = 0; i < 4; i++) begin
                    quot_reg[i] <= QW'(recip_w[i] >> DIV_K);
                end
                div_phase_reg <= 1'b0;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    rem_reg[i] <= coord_reg[i] - CW'(quot_reg[i]) * SCALE_CW;
                end
            end
        end

        if (cmd.prep) begin
            dx_reg     <= coord_reg[2] - coord_reg[0];
            dy_reg     <= $signed({1'b0, coord_reg[3]}) - $signed({1'b0, coord_reg[1]});
            rising_reg <= coord_reg[3] > coord_reg[1];
            vert_reg   <= quot_reg[0] == quot_reg[2];
            first_reg  <= TWO_S_M1 - (RW'(rem_reg[0]) << 1);
            lastw_reg  <= (RW'(rem_reg[2]) << 1) | RW'(1);
            ey1_reg    <= (RW'(rem_reg[1]) << 1) | RW'(1);
        end

        if (cmd.mul) begin
            p1_reg   <= ERR_W'(p1_w);
            p2_reg   <= ERR_W'(p2_w);
            den_reg  <= ERR_W'(den_w);
            step_reg <= ERR_W'(step_w);
            dyl_reg  <= ERR_W'(dyl_w);
        end

        if (cmd.init) begin
            err_reg   <= p1_reg + p2_reg;
            cx_reg    <= LW'(quot_reg[0]);
            cy_reg    <= (vert_reg && quot_reg[3] < quot_reg[1]) ?
                         LW'(quot_reg[3]) : LW'(quot_reg[1]);
            ymax_reg  <= (quot_reg[3] < quot_reg[1]) ? LW'(quot_reg[1]) : LW'(quot_reg[3]);
            ecx_reg   <= LW'(quot_reg[2]);
            final_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (cmd.advance) begin
            cell_x_reg    <= cx_reg;
            cell_y_reg    <= cy_reg;
            last_cell_reg <= cell_last;
            cnt_reg       <= cnt_reg + 1'b1;
            if (adv_y) begin
                cy_reg  <= cy_step;
                err_reg <= err_adj;
            end else if (!vert_reg && !final_reg) begin
                cx_reg    <= cx_inc;
                err_reg   <= err_col;
                final_reg <= fin_next;
                if (corner) begin
                    cy_reg <= cy_step;
                end
            end
        end
    end

    assign sts.div_done  = !div_phase_reg;
    assign sts.cell_last = cell_last;
    assign cell_x        = cell_x_reg;
    assign cell_y        = cell_y_reg;
    assign last_cell     = last_cell_reg;

endmodule

[sv/srct_ctrl.sv]
// ============================================================================
// srct_ctrl
// Controller: sequences setup steps per ray, runs the cell walk and owns
// the handshake state of both channels.
// ============================================================================
module srct_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output srct_pkg::cmd_t cmd,
    input  srct_pkg::sts_t sts
);

    srct_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             advance;

    assign advance = (state_reg == srct_pkg::ST_WALK) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srct_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = srct_pkg::ST_DIV;
                end
            end
            srct_pkg::ST_DIV: begin
                if (sts.div_done) begin
                    state_next = srct_pkg::ST_PREP;
                end
            end
            srct_pkg::ST_PREP: state_next = srct_pkg::ST_MUL;
            srct_pkg::ST_MUL:  state_next = srct_pkg::ST_INIT;
            srct_pkg::ST_INIT: state_next = srct_pkg::ST_WALK;
            srct_pkg::ST_WALK: begin
                if (advance && sts.cell_last) begin
                    state_next = srct_pkg::ST_IDLE;
                end
            end
            default: state_next = srct_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        case (state_reg)
            srct_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            srct_pkg::ST_DIV:  cmd.div_step = 1'b1;
            srct_pkg::ST_PREP: cmd.prep     = 1'b1;
            srct_pkg::ST_MUL:  cmd.mul      = 1'b1;
            srct_pkg::ST_INIT: cmd.init     = 1'b1;
            srct_pkg::ST_WALK: begin
                cmd.advance = advance;
                if (advance) begin
                    out_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= srct_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[sv/subpixel_ray_cell_traversal.sv]
// ============================================================================
// subpixel_ray_cell_traversal
// Supercover walk of a ray given in subpixel units over a square cell grid.
// ============================================================================
// Usage:
//   Slave channel takes one ray per transaction: begin and end points in
//   subpixel units. Master channel returns the cells the segment touches,
//   at most 63, in walk order, one cell per transaction, with m_tlast on
//   the final cell. Coordinates beyond the grid are clamped to its edge.
// Setup: after a ray is accepted, the first cell shows on m_tvalid once
//   cell index division (reciprocal multiply, then remainder), prep,
//   multiply, error term init and the first walk step have run.
// Throughput: a ray yields at most 63 cells; while m_tready stays high
//   the walk emits one cell per cycle from the single error term update.
//   s_tready is high only between rays; the next ray is taken while the
//   last cell of the previous one still waits in the output register.
// Reset: synchronous, active low; drops m_tvalid and returns to idle.
// Stall: with m_tready low the walk holds and the output stays stable.
// ============================================================================
module subpixel_ray_cell_traversal #(
    parameter int GRID_CELLS     = srct_pkg::GRID_CELLS_DEF,
    parameter int SUBPIXEL_SCALE = srct_pkg::SUBPIXEL_SCALE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_x[14:0], start_y[29:15], stop_x[44:30], stop_y[59:45], zero pad
    input  logic [srct_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cell_x[4:0], cell_y[9:5], zero pad
    output logic [srct_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    localparam int CW = srct_pkg::COORD_W;
    localparam int LW = srct_pkg::CELL_W;

    srct_pkg::cmd_t cmd;
    srct_pkg::sts_t sts;
    logic [LW-1:0]  cell_x, cell_y;

    srct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    srct_dp #(
        .GRID_CELLS     (GRID_CELLS),
        .SUBPIXEL_SCALE (SUBPIXEL_SCALE)
    ) u_dp (
        .aclk      (aclk),
        .cmd       (cmd),
        .sts       (sts),
        .start_x   (s_tdata[CW-1:0]),
        .start_y   (s_tdata[2*CW-1:CW]),
        .stop_x    (s_tdata[3*CW-1:2*CW]),
        .stop_y    (s_tdata[4*CW-1:3*CW]),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .last_cell (m_tlast)
    );

    assign m_tdata = {{(srct_pkg::M_TDATA_W - 2*LW){1'b0}}, cell_y, cell_x};

endmodule

[sv/srct_checker.sv]
// ============================================================================
// srct_checker
// Port-level checks on the ray traversal block, bound to the top level.
// ============================================================================
module srct_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [srct_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ray accepted while previous ray in setup");

    a_no_accept_mid_ray: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready before ray walk finished");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !$isunknown(s_tready))
        else $error("output valid after reset");

endmodule

bind subpixel_ray_cell_traversal srct_checker u_srct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
